FILE: rtl/rgb_convolution_3x3_top_assert.svh
// Assertion macros shared by the checker of the 3x3 convolution block.
// Needs signals named aclk and aresetn in the scope where a macro is used.
`ifndef RGB_CONVOLUTION_3X3_TOP_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_TOP_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define RGBC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rgbc check failed");

// Next-cycle implication, checked only out of reset.
`define RGBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rgbc check failed");

// Next-cycle implication that is also checked while reset is applied.
`define RGBC_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rgbc check failed");

`endif

FILE: rtl/rgbc_pkg.sv
// Package of the RGB 3x3 convolution block: sizes, register indexes and shared types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rgbc_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int LINE_AW        = $clog2(MAX_WIDTH);
    localparam int COEF_FRAC_BITS = 12;
    localparam int COEF_W         = 16;
    localparam int PIX_W          = 8;
    localparam int PIX_MAX        = 255;
    localparam int RGB_W          = 3 * PIX_W;
    localparam int LINE_W         = 2 * RGB_W;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 12;
    localparam int ROW_W          = HEIGHT_W + 1;
    localparam int KROW_W         = 3 * COEF_W;
    localparam int PROD_W         = PIX_W + 1 + COEF_W;
    localparam int RSUM_W         = PROD_W + 2;
    localparam int TSUM_W         = PROD_W + 4;
    localparam int FIFO_DEPTH     = 8;
    localparam int FIFO_AW        = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = FIFO_AW + 1;
    localparam int APB_AW         = 6;
    localparam int APB_DW         = 64;
    localparam int KMID_RESET     = 4096;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MIDDLE = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } reg_idx_t;

    typedef logic [RGB_W-1:0] rgb_t;
    typedef rgb_t [8:0] window_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } tag_t;

    typedef struct packed {
        logic last;
        rgb_t rgb;
    } result_t;

endpackage

FILE: rtl/rgbc_filter.sv
// Filter pipeline of the RGB 3x3 convolution: 27 products, row sums, total, round and clamp.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_filter
    import rgbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  tag_t              in_tag,
    input  window_t           win,
    input  logic [KROW_W-1:0] k_top,
    input  logic [KROW_W-1:0] k_mid,
    input  logic [KROW_W-1:0] k_bot,
    output logic              out_valid,
    output result_t           out_result
);

    function automatic logic [PIX_W-1:0] round_clamp(input logic signed [TSUM_W-1:0] s);
        logic signed [TSUM_W-1:0]             biased;
        logic [TSUM_W-COEF_FRAC_BITS-1:0]     q;
        biased = s + $signed(TSUM_W'(1 << (COEF_FRAC_BITS - 1)));
        q      = biased[TSUM_W-1:COEF_FRAC_BITS];
        if (s <= 0) begin
            return '0;
        end else if (q > (TSUM_W-COEF_FRAC_BITS)'(PIX_MAX)) begin
            return PIX_W'(PIX_MAX);
        end else begin
            return q[PIX_W-1:0];
        end
    endfunction

    logic [KROW_W-1:0]        krows [3];
    logic signed [COEF_W-1:0] coef [9];
    logic signed [PIX_W:0]    px_s;

    logic signed [PROD_W-1:0] prod_next [3][9];
    logic signed [PROD_W-1:0] prod_reg  [3][9];
    logic signed [RSUM_W-1:0] rsum_next [3][3];
    logic signed [RSUM_W-1:0] rsum_reg  [3][3];
    logic signed [TSUM_W-1:0] tsum_next [3];
    logic signed [TSUM_W-1:0] tsum_reg  [3];

    logic    va_reg, vb_reg, vc_reg;
    tag_t    ta_reg, tb_reg, tc_reg;
    rgb_t    ca_reg, cb_reg, cc_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t out_result_next;

    always_comb begin
        krows[0] = k_top;
        krows[1] = k_mid;
        krows[2] = k_bot;
        px_s     = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r*3+c] = $signed(krows[r][COEF_W*c +: COEF_W]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++) begin
                px_s              = {1'b0, win[i][PIX_W*ch +: PIX_W]};
                prod_next[ch][i]  = px_s * coef[i];
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
                rsum_next[ch][r] = RSUM_W'(prod_reg[ch][3*r]) + RSUM_W'(prod_reg[ch][3*r+1])
                                 + RSUM_W'(prod_reg[ch][3*r+2]);
            end
            tsum_next[ch] = TSUM_W'(rsum_reg[ch][0]) + TSUM_W'(rsum_reg[ch][1])
                          + TSUM_W'(rsum_reg[ch][2]);
        end
    end

    // Border pixels keep the center of the window; interior ones take the filtered value.
    always_comb begin
        out_result_next.last = tc_reg.last;
        for (int ch = 0; ch < 3; ch++) begin
            out_result_next.rgb[PIX_W*ch +: PIX_W] = tc_reg.interior ?
                round_clamp(tsum_reg[ch]) : cc_reg[PIX_W*ch +: PIX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            va_reg        <= in_valid;
            vb_reg        <= va_reg;
            vc_reg        <= vb_reg;
            out_valid_reg <= vc_reg && tc_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg       <= prod_next;
        rsum_reg       <= rsum_next;
        tsum_reg       <= tsum_next;
        ta_reg         <= in_tag;
        tb_reg         <= ta_reg;
        tc_reg         <= tb_reg;
        ca_reg         <= win[4];
        cb_reg         <= ca_reg;
        cc_reg         <= cb_reg;
        out_result_reg <= out_result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

FILE: rtl/rgbc_out_fifo.sv
// Output queue of the RGB 3x3 convolution: holds finished words until the sink takes them.
// Depends on rgbc_pkg.
`timescale 1ns / 1ps

module rgbc_out_fifo
    import rgbc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    input  result_t          wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output result_t          rd_data,
    output logic [CNT_W-1:0] count
);

    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 pop;

    // The top level only issues words it has room for, so a push never meets a full queue.
    always_comb begin
        pop         = rd_valid && rd_ready;
        wr_ptr_next = wr_valid ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_valid) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            fifo_mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = fifo_mem[rd_ptr_reg];
    assign count    = count_reg;

endmodule

FILE: rtl/rgb_convolution_3x3_top.sv
// Channel      | Ports                                     | Word
// input pixel  | s_tvalid s_tready s_tdata s_tuser         | red, green, blue; tuser = mode
// result pixel | m_tvalid m_tready m_tdata m_tlast         | red, green, blue; tlast = frame end
// registers    | psel penable pwrite paddr pwdata prdata   | 64-bit, byte address 8 * index
//
// One word is taken per clock while s_tready is high; the two line rows share one
// memory with one read and one write port, read as a word is taken and written back
// the next cycle. Results pass the line read, window, product, row-sum, total and output
// registers into the 8-word output queue; s_tready needs room there beyond the results
// in flight, so a stalled sink holds the input only once eight results are pending.
// Reset is synchronous and needs no clearing pass; the line memory is not initialized.
// Depends on rgbc_pkg, rgbc_filter and rgbc_out_fifo.
`timescale 1ns / 1ps

module rgb_convolution_3x3_top
    import rgbc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [RGB_W-1:0]  s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic              s_tuser,   // mode: 0 pixel, 1 drain step
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [RGB_W-1:0]  m_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic              m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [KROW_W-1:0]   ktop_reg, kmid_reg, kbot_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    logic [LINE_AW-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    logic [WIDTH_W-1:0]  w_eff;
    logic [WIDTH_W-1:0]  col_inc;
    logic                empty, in_frame, accept, active;
    rgb_t                value;
    tag_t                tag;

    logic                s1_valid_reg, s1_fwd_reg;
    logic [LINE_AW-1:0]  s1_addr_reg;
    rgb_t                s1_value_reg;
    tag_t                s1_tag_reg;

    logic [LINE_W-1:0]   line_mem [MAX_WIDTH];
    logic [LINE_W-1:0]   line_rd_reg;
    logic [LINE_W-1:0]   wr_data_reg;
    logic [LINE_W-1:0]   line_word;
    rgb_t                top_pix, mid_pix;

    window_t             win_reg;
    logic                s2_valid_reg;
    tag_t                s2_tag_reg;

    logic                res_valid;
    result_t             res_data;
    result_t             q_data;
    logic [CNT_W-1:0]    q_count;
    logic [CNT_W-1:0]    in_flight_reg, in_flight_next;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
            ktop_reg   <= '0;
            kmid_reg   <= KROW_W'(KMID_RESET);
            kbot_reg   <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:   width_reg  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg <= pwdata[HEIGHT_W-1:0];
                REG_KERNEL_TOP:    ktop_reg   <= pwdata[KROW_W-1:0];
                REG_KERNEL_MIDDLE: kmid_reg   <= pwdata[KROW_W-1:0];
                REG_KERNEL_BOTTOM: kbot_reg   <= pwdata[KROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:   prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT:  prdata = APB_DW'(height_reg);
            REG_KERNEL_TOP:    prdata = APB_DW'(ktop_reg);
            REG_KERNEL_MIDDLE: prdata = APB_DW'(kmid_reg);
            REG_KERNEL_BOTTOM: prdata = APB_DW'(kbot_reg);
            default:           prdata = '0;
        endcase
    end

    // Position tracking. Rows past the image carry zero pixels and flush the window.
    always_comb begin
        w_eff    = (width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width_reg;
        empty    = (w_eff == '0) || (height_reg == '0);
        in_frame = row_reg < ROW_W'(height_reg);
        accept   = s_tvalid && s_tready;
        active   = accept && !empty && !(in_frame && s_tuser);
        value    = in_frame ? s_tdata : '0;
        col_inc  = WIDTH_W'(col_reg) + WIDTH_W'(1);

        tag.emit     = !((row_reg == '0) || ((row_reg == ROW_W'(1)) && (col_reg == '0)));
        tag.last     = row_reg > ROW_W'(height_reg);
        tag.interior = (col_reg >= LINE_AW'(2)) && (row_reg >= ROW_W'(2)) && in_frame;

        col_next = col_reg;
        row_next = row_reg;
        if (active) begin
            if (tag.last) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= w_eff) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_inc[LINE_AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= active;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // The word in stage one writes its column at the same edge the next word reads it, which
    // happens in rows one pixel wide or after a frame closes; that read takes the written data.
    always_ff @(posedge aclk) begin
        if (active) begin
            line_rd_reg  <= line_mem[col_reg];
            s1_fwd_reg   <= s1_valid_reg && (s1_addr_reg == col_reg);
            s1_addr_reg  <= col_reg;
            s1_value_reg <= value;
            s1_tag_reg   <= tag;
        end
        if (s1_valid_reg) begin
            line_mem[s1_addr_reg] <= {mid_pix, s1_value_reg};
            wr_data_reg           <= {mid_pix, s1_value_reg};
        end
    end

    always_comb begin
        line_word = s1_fwd_reg ? wr_data_reg : line_rd_reg;
        top_pix   = line_word[LINE_W-1:RGB_W];
        mid_pix   = line_word[RGB_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_valid_reg) begin
            for (int j = 0; j < 3; j++) begin
                win_reg[j*3]   <= win_reg[j*3+1];
                win_reg[j*3+1] <= win_reg[j*3+2];
            end
            win_reg[2] <= top_pix;
            win_reg[5] <= mid_pix;
            win_reg[8] <= s1_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_tag_reg <= s1_tag_reg;
    end

    rgbc_filter u_filter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s2_valid_reg),
        .in_tag     (s2_tag_reg),
        .win        (win_reg),
        .k_top      (ktop_reg),
        .k_mid      (kmid_reg),
        .k_bot      (kbot_reg),
        .out_valid  (res_valid),
        .out_result (res_data)
    );

    // Results still in the pipeline reserve their place in the queue.
    always_comb begin
        in_flight_next = in_flight_reg + CNT_W'(active && tag.emit) - CNT_W'(res_valid);
        s_tready       = ({1'b0, q_count} + {1'b0, in_flight_reg}) < (CNT_W+1)'(FIFO_DEPTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= '0;
        end else begin
            in_flight_reg <= in_flight_next;
        end
    end

    rgbc_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res_data),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (q_data),
        .count    (q_count)
    );

    assign m_tdata = q_data.rgb;
    assign m_tlast = q_data.last;

endmodule

FILE: rtl/rgbc_checker.sv
// Port-level checks of the RGB 3x3 convolution top level, bound to it below.
// Depends on rgbc_pkg and the assertion macros in rgb_convolution_3x3_top_assert.svh.
`timescale 1ns / 1ps
`include "rgb_convolution_3x3_top_assert.svh"

module rgbc_checker
    import rgbc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [RGB_W-1:0]  s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input logic              s_tuser,   // mode
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [RGB_W-1:0]  m_tdata,   // red [7:0], green [15:8], blue [23:16]
    input logic              m_tlast,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    // A result word that the sink has not taken stays in place.
    `RGBC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Reset leaves no result pending and the input open.
    `RGBC_ASSERT_NEXT_ALWAYS(a_reset_quiet, !aresetn, !m_tvalid && s_tready)

    // A height written is read back at once at the same address.
    `RGBC_ASSERT_NEXT(a_height_back, psel && penable && pwrite && pready && paddr[APB_AW-1:3] == REG_IMAGE_HEIGHT, paddr[APB_AW-1:3] != REG_IMAGE_HEIGHT || prdata[HEIGHT_W-1:0] == $past(pwdata[HEIGHT_W-1:0]))

endmodule

bind rgb_convolution_3x3_top rgbc_checker u_rgbc_checker (.*);

FILE: dv/rgb_convolution_3x3_top_tb.sv
// Self-checking testbench of rgb_convolution_3x3_top: a directed plan, then random frames.
// Each result is compared with a typed plan value or a behavioral 3x3 filter model in this file.
// Depends on rgbc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module rgb_convolution_3x3_top_tb;
    import rgbc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_WAIT      = 10;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_WORDS  = 600;
    localparam int PLAN_LEN      = 26;

    typedef enum logic {STEP_REG, STEP_WORD} step_kind_t;
    typedef enum logic {MODE_PIXEL, MODE_DRAIN} word_mode_t;
    typedef enum logic [2:0] {
        KERN_MILD, KERN_WILD, KERN_PEAK, KERN_FLOOR, KERN_NEG
    } kern_style_t;
    typedef enum logic [2:0] {
        PH_NO_WIDTH, PH_NO_HEIGHT, PH_PEAK, PH_FLOOR, PH_NEG, PH_RANDOM, PH_WIDE, PH_TALL
    } phase_kind_t;

    typedef struct packed {
        rgb_t rgb;
        logic last;
    } pixel_out_t;

    typedef struct packed {
        step_kind_t        kind;
        reg_idx_t          sel;
        logic [KROW_W-1:0] value;
        word_mode_t        mode;
        rgb_t              rgb;
        logic              typed;
        rgb_t              want_rgb;
        logic              want_last;
    } plan_step_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    rgb_t              s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    rgb_t              m_tdata;
    logic              m_tlast;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Filter model state: registers, the two stored rows, the window and the input position.
    logic [WIDTH_W-1:0]  cfg_width  = '0;
    logic [HEIGHT_W-1:0] cfg_height = '0;
    logic [KROW_W-1:0]   cfg_kernel [3] = '{48'd0, 48'(KMID_RESET), 48'd0};
    rgb_t                line_upper [MAX_WIDTH];
    rgb_t                line_lower [MAX_WIDTH];
    rgb_t                win [9] = '{default: '0};
    int unsigned         next_col = 0;
    int unsigned         next_row = 0;
    bit                  frame_closed = 1'b0;

    pixel_out_t  pending_pixels [$];
    int          fault_count   = 0;
    int          counted_words = 0;
    bit          src_calm  = 1'b0;
    bit          sink_calm = 1'b0;
    int          sink_wait = 0;

    // The first words hit an empty image; the 3x3 frame runs on the reset kernel, whose
    // only nonzero tap is 1.0 on the left of the middle row.
    plan_step_t plan [PLAN_LEN] = '{
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h123456, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'h000000, 1'b0, 24'h0, 1'b0},
        '{STEP_REG, REG_IMAGE_WIDTH, 48'd3, MODE_PIXEL, 24'h0, 1'b0, 24'h0, 1'b0},
        '{STEP_REG, REG_IMAGE_HEIGHT, 48'd3, MODE_PIXEL, 24'h0, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h0000FF, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'hABCDEF, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h00FF00, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'hFF0000, 1'b1, 24'h000000, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h808080, 1'b1, 24'hFFFFFF, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h7F7F7F, 1'b1, 24'h0000FF, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'hA5A55A, 1'b1, 24'h00FF00, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h010203, 1'b1, 24'h00FF00, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'h000000, 1'b1, 24'h808080, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'hC3C3C3, 1'b1, 24'h7F7F7F, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'h000000, 1'b1, 24'hA5A55A, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'h000000, 1'b1, 24'h010203, 1'b1},
        '{STEP_REG, REG_IMAGE_HEIGHT, 48'd1, MODE_PIXEL, 24'h0, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'hFEDCBA, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'h55AA55, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'hAA55AA, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'h000000, 1'b0, 24'h0, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'h000000, 1'b1, 24'hFEDCBA, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_PIXEL, 24'hFFFFFF, 1'b1, 24'h55AA55, 1'b0},
        '{STEP_WORD, REG_IMAGE_WIDTH, 48'h0, MODE_DRAIN, 24'h000000, 1'b1, 24'hAA55AA, 1'b1}
    };

    rgb_convolution_3x3_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // red [7:0], green [15:8], blue [23:16]
        .s_tuser  (s_tuser),   // mode: 0 pixel, 1 drain step
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // red [7:0], green [15:8], blue [23:16]
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic [APB_DW-1:0] reg_mask(reg_idx_t sel);
        case (sel)
            REG_IMAGE_WIDTH:  return APB_DW'({WIDTH_W{1'b1}});
            REG_IMAGE_HEIGHT: return APB_DW'({HEIGHT_W{1'b1}});
            default:          return APB_DW'({KROW_W{1'b1}});
        endcase
    endfunction

    // Weighted sum of one channel over the window, rounded half away from zero and clamped.
    function automatic logic [PIX_W-1:0] filter_channel(int shift);
        longint                    acc;
        longint                    q;
        logic signed [COEF_W-1:0]  coef;
        acc = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef = cfg_kernel[r][COEF_W*c +: COEF_W];
                acc += longint'(win[r*3+c][shift +: PIX_W]) * longint'(coef);
            end
        end
        if (acc <= 0) return '0;
        q = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        return (q > PIX_MAX) ? PIX_W'(PIX_MAX) : q[PIX_W-1:0];
    endfunction

    // Advances the filter model by one accepted word; returns 1 when it yields a result.
    function automatic bit filter_step(word_mode_t mode, rgb_t pix, output pixel_out_t res);
        longint      w;
        longint      h;
        longint      total;
        longint      k;
        longint      r;
        longint      c;
        int unsigned col;
        int unsigned row;
        rgb_t        value;
        rgb_t        top;
        rgb_t        mid;
        bit          interior;
        res = '0;
        w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
        h = cfg_height;
        if (w == 0 || h == 0) return 1'b0;
        total = w * h;
        col = next_col;
        row = next_row;
        k = longint'(row) * w + col;
        if (k < total) begin
            if (mode == MODE_DRAIN) return 1'b0;
            value = pix;
        end else begin
            value = '0;
        end

        top = line_upper[col];
        mid = line_lower[col];
        line_upper[col] = mid;
        line_lower[col] = value;
        for (int j = 0; j < 3; j++) begin
            win[j*3]   = win[j*3+1];
            win[j*3+1] = win[j*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = value;

        if (col + 1 >= w) begin
            next_col = 0;
            next_row = row + 1;
        end else begin
            next_col = col + 1;
        end

        if (k < w + 1) return 1'b0;
        // The window center trails the input by one row and one pixel.
        if (col == 0) begin
            c = w - 1;
            r = longint'(row) - 2;
        end else begin
            c = longint'(col) - 1;
            r = longint'(row) - 1;
        end
        interior = (r >= 1) && (r + 2 <= h) && (c >= 1) && (c + 2 <= w);
        for (int ch = 0; ch < 3; ch++) begin
            res.rgb[PIX_W*ch +: PIX_W] = interior ? filter_channel(PIX_W * ch)
                                                  : win[4][PIX_W*ch +: PIX_W];
        end
        res.last = (k - w >= total);
        if (res.last) begin
            next_col = 0;
            next_row = 0;
            frame_closed = 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic report_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) report_fault($sformatf("%s expected %0h, got %0h", name, want, got));
    endtask

    // Result side: checks each accepted word and draws the stall before the next one.
    always @(posedge aclk) begin : result_sink
        pixel_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_pixels.size() == 0) begin
                    report_fault($sformatf("result %h last %b with nothing pending",
                                           m_tdata, m_tlast));
                end else begin
                    want = pending_pixels.pop_front();
                    compare_field("red", want.rgb[7:0], m_tdata[7:0]);
                    compare_field("green", want.rgb[15:8], m_tdata[15:8]);
                    compare_field("blue", want.rgb[23:16], m_tdata[23:16]);
                    compare_field("frame end", want.last, m_tlast);
                end
                sink_wait = draw_wait(sink_calm);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Register write followed by a read back of the same register.
    task automatic reg_write(reg_idx_t sel, logic [KROW_W-1:0] value);
        logic [APB_DW-1:0] kept;
        kept = APB_DW'(value) & reg_mask(sel);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= APB_DW'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        compare_field($sformatf("register %s", sel.name()), kept, prdata & reg_mask(sel));
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_IMAGE_WIDTH:   cfg_width = kept[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_height = kept[HEIGHT_W-1:0];
            REG_KERNEL_TOP:    cfg_kernel[0] = kept[KROW_W-1:0];
            REG_KERNEL_MIDDLE: cfg_kernel[1] = kept[KROW_W-1:0];
            REG_KERNEL_BOTTOM: cfg_kernel[2] = kept[KROW_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every expected result has left, then lets the pipeline run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_word(word_mode_t mode, rgb_t pix, bit typed, pixel_out_t typed_res);
        int         gap;
        pixel_out_t res;
        gap = draw_wait(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        if (filter_step(mode, pix, res) || typed)
            pending_pixels.push_back(typed ? typed_res : res);
    endtask

    function automatic logic [KROW_W-1:0] draw_kernel_row(kern_style_t style);
        logic [KROW_W-1:0] row;
        int                coef;
        for (int c = 0; c < 3; c++) begin
            case (style)
                KERN_MILD:  coef = int'($urandom_range(0, 3072)) - 1536;
                KERN_WILD:  coef = $urandom();
                KERN_PEAK:  coef = 'h7FFF;
                KERN_FLOOR: coef = 'h8000;
                default:    coef = 'hFFFF;
            endcase
            row[COEF_W*c +: COEF_W] = coef[COEF_W-1:0];
        end
        return row;
    endfunction

    // One frame of random pixels with stray early drains, then drains until the frame closes.
    task automatic run_frame();
        longint pixels;
        longint placed;
        pixels = longint'((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width) * cfg_height;
        placed = 0;
        frame_closed = 1'b0;
        while (placed < pixels) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(MODE_DRAIN, 24'($urandom()), 1'b0, '0);
            end else begin
                send_word(MODE_PIXEL, 24'($urandom()), 1'b0, '0);
                placed++;
                counted_words++;
            end
        end
        while (!frame_closed) begin
            // A pixel sent after the frame is complete acts as a drain step.
            send_word(($urandom_range(0, 3) == 0) ? MODE_PIXEL : MODE_DRAIN,
                      24'($urandom()), 1'b0, '0);
            counted_words++;
        end
    endtask

    task automatic run_phase(phase_kind_t kind);
        logic [WIDTH_W-1:0]  w;
        logic [HEIGHT_W-1:0] h;
        kern_style_t         style [3];
        int                  frames;
        int                  pace;
        w = WIDTH_W'($urandom_range(3, 8));
        h = HEIGHT_W'($urandom_range(3, 5));
        frames = $urandom_range(1, 3);
        pace = $urandom_range(0, 3);
        foreach (style[i]) style[i] = kern_style_t'($urandom_range(KERN_MILD, KERN_WILD));
        case (kind)
            PH_NO_WIDTH:  begin
                w = '0;
                h = HEIGHT_W'($urandom());
            end
            PH_NO_HEIGHT: begin
                w = WIDTH_W'($urandom());
                h = '0;
            end
            PH_PEAK:      foreach (style[i]) style[i] = KERN_PEAK;
            PH_FLOOR:     foreach (style[i]) style[i] = KERN_FLOOR;
            PH_NEG:       foreach (style[i]) style[i] = KERN_NEG;
            PH_WIDE:      begin
                w = '1;
                h = HEIGHT_W'(3);
                frames = 1;
                pace = 0;
                foreach (style[i]) style[i] = KERN_MILD;
            end
            PH_TALL:      begin
                w = WIDTH_W'(1);
                h = '1;
                frames = 1;
                pace = 0;
            end
            default:      begin
                w = ($urandom_range(0, 9) == 0) ? WIDTH_W'($urandom_range(9, 40))
                                                : WIDTH_W'($urandom_range(1, 8));
                h = HEIGHT_W'($urandom_range(1, 6));
                if ($urandom_range(0, 15) == 0) w = '0;
                if ($urandom_range(0, 15) == 0) h = '0;
                if ($urandom_range(0, 3) == 0)
                    foreach (style[i]) style[i] = kern_style_t'($urandom_range(0, 4));
            end
        endcase

        settle();
        // Pace 0 runs both sides flat out; pace 1 keeps the source busy against a stalling sink.
        src_calm  = (pace <= 1);
        sink_calm = (pace == 0);
        reg_write(REG_IMAGE_WIDTH, KROW_W'(w));
        reg_write(REG_IMAGE_HEIGHT, KROW_W'(h));
        reg_write(REG_KERNEL_TOP, draw_kernel_row(style[0]));
        reg_write(REG_KERNEL_MIDDLE, draw_kernel_row(style[1]));
        reg_write(REG_KERNEL_BOTTOM, draw_kernel_row(style[2]));
        if (w == 0 || h == 0) begin
            repeat ($urandom_range(2, 6))
                send_word(word_mode_t'($urandom_range(0, 1)), 24'($urandom()), 1'b0, '0);
        end else begin
            repeat (frames) run_frame();
        end
    endtask

    initial begin : stimulus
        pixel_out_t typed_res;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == STEP_REG) begin
                settle();
                reg_write(plan[i].sel, plan[i].value);
            end else begin
                typed_res.rgb  = plan[i].want_rgb;
                typed_res.last = plan[i].want_last;
                send_word(plan[i].mode, plan[i].rgb, plan[i].typed, typed_res);
            end
        end

        for (int k = PH_NO_WIDTH; k <= PH_NEG; k++) run_phase(phase_kind_t'(k));
        while (counted_words < RANDOM_WORDS) run_phase(PH_RANDOM);
        run_phase(PH_WIDE);
        run_phase(PH_TALL);

        settle();
        if (fault_count == 0) begin
            $display("[rgb_convolution_3x3_top] OK");
        end else begin
            $display("[rgb_convolution_3x3_top] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("[rgb_convolution_3x3_top] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rgbc_pkg.sv
rtl/rgbc_filter.sv
rtl/rgbc_out_fifo.sv
rtl/rgb_convolution_3x3_top.sv
rtl/rgbc_checker.sv
dv/rgb_convolution_3x3_top_tb.sv
